### design/nqs_pkg.sv
// ----------------------------------------------------------------------------
// N-queens search package
// Shared widths, default sizes and the command and status types that pass
// between the search controller and the search datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package nqs_pkg;

  localparam int MAX_SIZE_DEFAULT = 16;
  localparam int RESULT_LIMIT     = 16;
  localparam int SIZE_W           = 5;
  localparam int ROW_OUT_W        = 4;
  localparam int COL_OUT_W        = 4;

  function automatic int board_limit(input int max_size);
    board_limit = (max_size < RESULT_LIMIT) ? max_size : RESULT_LIMIT;
  endfunction

  typedef struct packed {
    logic load;
    logic place;
    logic advance;
    logic backtrack;
    logic emit;
    logic emit_fail;
  } cmd_t;

  typedef struct packed {
    logic size_ok;
    logic col_end;
    logic row_zero;
    logic square_free;
    logic last_row;
    logic emit_last;
  } status_t;

endpackage

`default_nettype wire

### design/n_queens_first_solution_search_top.sv
// ----------------------------------------------------------------------------
// N-queens first-solution search
// A request transfer on start with board_size launches a depth-first
// backtracking search; busy stays high until the last result has been issued,
// and that result is shown in the first cycle with busy low again.
// The first solution is returned as one result per row, in row order, each
// shown for one cycle with valid high: row_number, queen_col, found set and
// last on the final row. Sizes with no solution, zero, or sizes above the
// board limit (the smaller of MAX_SIZE and 16) give one result with found
// clear and last set.
// The request is loaded first; the search then tries the columns of each
// row in turn and steps back a row when a row runs out of columns, and the
// result rows follow. Each result is registered and appears in the cycle
// after the cycle that issues it. A rejected size or an exhausted search
// issues its single result instead. A new request is taken only while busy
// is low, one at a time. The receiver cannot stall: each result is taken in
// the cycle it is shown. Reset clears the occupancy masks and the controller
// and drops valid.
// ----------------------------------------------------------------------------
`default_nettype none

module n_queens_first_solution_search_top #(
  parameter int MAX_SIZE = nqs_pkg::MAX_SIZE_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [nqs_pkg::SIZE_W-1:0]     board_size,
  output logic                           valid,
  output logic [nqs_pkg::ROW_OUT_W-1:0]  row_number,
  output logic [nqs_pkg::COL_OUT_W-1:0]  queen_col,
  output logic                           found,
  output logic                           last
);
  import nqs_pkg::*;

  cmd_t    cmd;
  status_t status;

  nqs_controller u_controller (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  nqs_datapath #(
    .MAX_SIZE (MAX_SIZE)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .board_size (board_size),
    .cmd        (cmd),
    .status     (status),
    .valid      (valid),
    .row_number (row_number),
    .queen_col  (queen_col),
    .found      (found),
    .last       (last)
  );

endmodule

`default_nettype wire

### design/nqs_datapath.sv
// ----------------------------------------------------------------------------
// N-queens search datapath
// Holds the board size, the search position, the occupancy masks and the
// column placed in each row, and drives the registered result ports.
// ----------------------------------------------------------------------------
`default_nettype none

module nqs_datapath #(
  parameter int MAX_SIZE = nqs_pkg::MAX_SIZE_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [nqs_pkg::SIZE_W-1:0]     board_size,
  input  nqs_pkg::cmd_t                  cmd,
  output nqs_pkg::status_t               status,
  output logic                           valid,
  output logic [nqs_pkg::ROW_OUT_W-1:0]  row_number,
  output logic [nqs_pkg::COL_OUT_W-1:0]  queen_col,
  output logic                           found,
  output logic                           last
);
  import nqs_pkg::*;

  localparam int BOARD_MAX = board_limit(MAX_SIZE);
  localparam int CW        = (BOARD_MAX > 1) ? $clog2(BOARD_MAX) : 1;
  localparam int RW        = $clog2(BOARD_MAX + 1);
  localparam int DW        = 2 * BOARD_MAX - 1;
  localparam int DIW       = $clog2(DW);
  localparam int XW        = DIW + 1;

  logic [RW-1:0]        size_n;
  logic                 size_ok;
  logic [RW-1:0]        row;
  logic [RW-1:0]        col;
  logic [RW-1:0]        out_row;
  logic [BOARD_MAX-1:0] column_taken;
  logic [DW-1:0]        down_taken;
  logic [DW-1:0]        up_taken;
  logic [CW-1:0]        placed [BOARD_MAX];

  logic [RW-1:0]  row_prev;
  logic [RW-1:0]  rd_addr;
  logic [CW-1:0]  rd_col;
  logic [CW-1:0]  col_idx;
  logic [DIW-1:0] down_idx;
  logic [DIW-1:0] up_idx;
  logic [DIW-1:0] bt_down_idx;
  logic [DIW-1:0] bt_up_idx;

  assign row_prev = row - RW'(1);
  assign rd_addr  = cmd.emit ? out_row : row_prev;
  assign rd_col   = placed[rd_addr[CW-1:0]];
  assign col_idx  = col[CW-1:0];

  assign down_idx    = DIW'(XW'(row) + XW'(BOARD_MAX - 1) - XW'(col));
  assign up_idx      = DIW'(XW'(row) + XW'(col));
  assign bt_down_idx = DIW'(XW'(row_prev) + XW'(BOARD_MAX - 1) - XW'(rd_col));
  assign bt_up_idx   = DIW'(XW'(row_prev) + XW'(rd_col));

  always_comb begin
    status.size_ok     = size_ok;
    status.col_end     = (col == size_n);
    status.row_zero    = (row == '0);
    status.square_free = !column_taken[col_idx] && !down_taken[down_idx] &&
                         !up_taken[up_idx];
    status.last_row    = (row == size_n - RW'(1));
    status.emit_last   = (out_row == size_n - RW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_n       <= '0;
      size_ok      <= 1'b0;
      row          <= '0;
      col          <= '0;
      out_row      <= '0;
      column_taken <= '0;
      down_taken   <= '0;
      up_taken     <= '0;
    end else if (cmd.load) begin
      size_n       <= RW'(board_size);
      size_ok      <= (board_size != '0) && (board_size <= SIZE_W'(BOARD_MAX));
      row          <= '0;
      col          <= '0;
      out_row      <= '0;
      column_taken <= '0;
      down_taken   <= '0;
      up_taken     <= '0;
    end else if (cmd.place) begin
      column_taken <= column_taken | (BOARD_MAX'(1) << col_idx);
      down_taken   <= down_taken | (DW'(1) << down_idx);
      up_taken     <= up_taken | (DW'(1) << up_idx);
      row          <= row + RW'(1);
      col          <= '0;
    end else if (cmd.advance) begin
      col <= col + RW'(1);
    end else if (cmd.backtrack) begin
      column_taken <= column_taken & ~(BOARD_MAX'(1) << rd_col);
      down_taken   <= down_taken & ~(DW'(1) << bt_down_idx);
      up_taken     <= up_taken & ~(DW'(1) << bt_up_idx);
      row          <= row_prev;
      col          <= RW'(rd_col) + RW'(1);
    end else if (cmd.emit) begin
      out_row <= out_row + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.place) begin
      placed[row[CW-1:0]] <= col_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmd.emit || cmd.emit_fail;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      row_number <= ROW_OUT_W'(out_row);
      queen_col  <= COL_OUT_W'(rd_col);
      found      <= 1'b1;
      last       <= status.emit_last;
    end else if (cmd.emit_fail) begin
      row_number <= '0;
      queen_col  <= '0;
      found      <= 1'b0;
      last       <= 1'b1;
    end
  end

endmodule

`default_nettype wire

### design/nqs_controller.sv
// ----------------------------------------------------------------------------
// N-queens search controller
// Sequences request intake, the column-by-column backtracking search and the
// per-row result transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module nqs_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  nqs_pkg::status_t status,
  output nqs_pkg::cmd_t    cmd,
  output logic             busy
);
  import nqs_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        priority if (!status.size_ok) begin
          cmd.emit_fail = 1'b1;
          state_next    = ST_IDLE;
        end else if (status.col_end) begin
          if (status.row_zero) begin
            cmd.emit_fail = 1'b1;
            state_next    = ST_IDLE;
          end else begin
            cmd.backtrack = 1'b1;
          end
        end else if (status.square_free) begin
          cmd.place = 1'b1;
          if (status.last_row) begin
            state_next = ST_EMIT;
          end
        end else begin
          cmd.advance = 1'b1;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire
